>>> rtl/core/tkmh_pkg.sv
`timescale 1ns / 1ps
// Package for the top-k min-heap core: entry and payload types, codes and
// the controller state type. Has no dependencies.
package tkmh_pkg;

  localparam int HEAP_DEPTH_DEF = 32;
  localparam int WORD_W         = 16;
  localparam int COUNT_W        = 32;
  localparam int SIZE_W         = 6;
  localparam int ADDR_W         = 6;
  localparam logic [SIZE_W-1:0] SIZE_RESET = 6'd32;

  localparam logic OP_REPLACE = 1'b0;
  localparam logic OP_SORT    = 1'b1;

  typedef struct packed {
    logic               opcode;
    logic [WORD_W-1:0]  new_word_id;
    logic [COUNT_W-1:0] new_count;
  } in_item_t;

  typedef struct packed {
    logic [WORD_W-1:0]  word_id;
    logic [COUNT_W-1:0] count;
    logic               occupied;
    logic               last;
  } out_item_t;

  typedef struct packed {
    logic               used;
    logic [WORD_W-1:0]  word;
    logic [COUNT_W-1:0] count;
  } entry_t;

  typedef struct packed {
    logic [ADDR_W-1:0] rd_a;
    logic [ADDR_W-1:0] rd_b;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    entry_t            wr_data;
  } mem_req_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SIFT_RD,
    ST_SIFT_CMP,
    ST_SORT_RD,
    ST_SORT_SWAP,
    ST_ROOT_RD,
    ST_ROOT_OUT,
    ST_EMIT_RD,
    ST_EMIT_OUT
  } state_t;

endpackage

>>> rtl/core/top_k_min_heap_core.sv
`timescale 1ns / 1ps
// Top level of the top-k min-heap core: entry store plus controller.
// Depends on tkmh_pkg, tkmh_store and tkmh_ctrl.
//
// A binary min-heap of word counts held in a two-read, one-write entry store
// with registered read ports; every entry is empty with count 0 after reset.
// A replace transfer (opcode 0) overwrites the root and sifts it down; each
// heap level reads both children, then compares and writes back one entry,
// and the transfer gives one result. A sort transfer (opcode 1) runs an
// in-place heapsort over the k active entries, one sift-down per removed
// root, then emits all k entries in descending count order, the last
// flagged; the sift loop on the store's ports sets the cost of the sort.
// The active size register may be written only while the core is idle.
module top_k_min_heap_core #(
  parameter int HEAP_DEPTH = tkmh_pkg::HEAP_DEPTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  tkmh_pkg::in_item_t          in_data,
  output logic                        out_valid,
  input  logic                        out_stall,
  output tkmh_pkg::out_item_t         out_data,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [tkmh_pkg::SIZE_W-1:0] cfg_active_size
);

  tkmh_pkg::mem_req_t req;
  tkmh_pkg::entry_t   rd_data_a;
  tkmh_pkg::entry_t   rd_data_b;

  tkmh_store #(
    .HEAP_DEPTH(HEAP_DEPTH)
  ) u_store (
    .clk       (clk),
    .rst_n     (rst_n),
    .req       (req),
    .rd_data_a (rd_data_a),
    .rd_data_b (rd_data_b)
  );

  tkmh_ctrl #(
    .HEAP_DEPTH(HEAP_DEPTH)
  ) u_ctrl (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_data         (in_data),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_data        (out_data),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_active_size (cfg_active_size),
    .req             (req),
    .rd_data_a       (rd_data_a),
    .rd_data_b       (rd_data_b)
  );

endmodule

>>> rtl/core/tkmh_store.sv
`timescale 1ns / 1ps
// Heap entry store: one write port and two registered read ports, with a
// written flag per entry so that unwritten entries read as empty after reset.
// Depends on tkmh_pkg.
module tkmh_store #(
  parameter int HEAP_DEPTH = tkmh_pkg::HEAP_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  tkmh_pkg::mem_req_t req,
  output tkmh_pkg::entry_t  rd_data_a,
  output tkmh_pkg::entry_t  rd_data_b
);

  localparam int IW = (HEAP_DEPTH > 1) ? $clog2(HEAP_DEPTH) : 1;

  tkmh_pkg::entry_t mem_r [HEAP_DEPTH];
  logic [HEAP_DEPTH-1:0] filled_r;
  tkmh_pkg::entry_t rd_a_r;
  tkmh_pkg::entry_t rd_b_r;
  logic rd_a_ok_r;
  logic rd_b_ok_r;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem_r[req.wr_addr[IW-1:0]] <= req.wr_data;
    end
    rd_a_r    <= mem_r[req.rd_a[IW-1:0]];
    rd_b_r    <= mem_r[req.rd_b[IW-1:0]];
    rd_a_ok_r <= filled_r[req.rd_a[IW-1:0]];
    rd_b_ok_r <= filled_r[req.rd_b[IW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      filled_r <= '0;
    end else if (req.wr_en) begin
      filled_r[req.wr_addr[IW-1:0]] <= 1'b1;
    end
  end

  assign rd_data_a = rd_a_ok_r ? rd_a_r : '0;
  assign rd_data_b = rd_b_ok_r ? rd_b_r : '0;

endmodule

>>> rtl/core/tkmh_ctrl.sv
`timescale 1ns / 1ps
// Heap controller: sift-down and heapsort sequencer, size register and the
// output register. Drives the entry store. Depends on tkmh_pkg.
module tkmh_ctrl #(
  parameter int HEAP_DEPTH = tkmh_pkg::HEAP_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  tkmh_pkg::in_item_t            in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output tkmh_pkg::out_item_t           out_data,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [tkmh_pkg::SIZE_W-1:0]   cfg_active_size,
  output tkmh_pkg::mem_req_t            req,
  input  tkmh_pkg::entry_t              rd_data_a,
  input  tkmh_pkg::entry_t              rd_data_b
);

  localparam int IW = (HEAP_DEPTH > 1) ? $clog2(HEAP_DEPTH) : 1;
  localparam int NW = IW + 1;
  localparam int CW = IW + 2;
  localparam int SW = tkmh_pkg::SIZE_W;

  tkmh_pkg::state_t state_r, state_nxt;
  logic [SW-1:0]    size_r;
  tkmh_pkg::entry_t held_r;
  logic [IW-1:0]    t_r;
  logic [IW-1:0]    top_r;
  logic [IW-1:0]    j_r;
  logic [IW-1:0]    e_r;
  logic [IW-1:0]    last_idx_r;
  logic             sort_mode_r;
  logic             out_valid_r;
  tkmh_pkg::out_item_t out_item_r;

  logic [SW:0]    size_clamp;
  logic [NW-1:0]  n_eff;
  logic [NW-1:0]  n_m1;
  logic [IW-1:0]  last_idx;
  logic           in_xfer;
  logic [CW-1:0]  left_idx;
  logic [CW-1:0]  right_idx;
  logic           left_ok;
  logic           right_ok;
  logic           cand_left;
  logic [tkmh_pkg::COUNT_W-1:0] cand_count;
  logic           pick_right;
  logic           move;
  tkmh_pkg::entry_t win_entry;
  logic [IW-1:0]  win_idx;
  logic           sift_done;
  logic           can_load;
  logic           out_load;
  logic           out_last;

  always_comb begin
    if (size_r == '0) begin
      size_clamp = (SW+1)'(1);
    end else if ({1'b0, size_r} > (SW+1)'(HEAP_DEPTH)) begin
      size_clamp = (SW+1)'(HEAP_DEPTH);
    end else begin
      size_clamp = {1'b0, size_r};
    end
    n_eff    = size_clamp[NW-1:0];
    n_m1     = n_eff - NW'(1);
    last_idx = n_m1[IW-1:0];
  end

  assign in_xfer   = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign can_load  = !out_valid_r || !out_stall;

  always_comb begin
    left_idx   = {1'b0, t_r, 1'b1};
    right_idx  = left_idx + CW'(1);
    left_ok    = left_idx <= CW'(top_r);
    right_ok   = right_idx <= CW'(top_r);
    cand_left  = rd_data_a.count < held_r.count;
    cand_count = cand_left ? rd_data_a.count : held_r.count;
    pick_right = right_ok && !(cand_count < rd_data_b.count);
    move       = pick_right || cand_left;
    win_entry  = pick_right ? rd_data_b : rd_data_a;
    win_idx    = pick_right ? right_idx[IW-1:0] : left_idx[IW-1:0];
    sift_done  = ((state_r == tkmh_pkg::ST_SIFT_RD) && !left_ok) ||
                 ((state_r == tkmh_pkg::ST_SIFT_CMP) && !move);
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      tkmh_pkg::ST_IDLE: begin
        if (in_valid) begin
          if (in_data.opcode == tkmh_pkg::OP_REPLACE) begin
            state_nxt = tkmh_pkg::ST_SIFT_RD;
          end else if (last_idx == '0) begin
            state_nxt = tkmh_pkg::ST_EMIT_RD;
          end else begin
            state_nxt = tkmh_pkg::ST_SORT_RD;
          end
        end
      end
      tkmh_pkg::ST_SIFT_RD, tkmh_pkg::ST_SIFT_CMP: begin
        if (sift_done) begin
          if (!sort_mode_r) begin
            state_nxt = tkmh_pkg::ST_ROOT_RD;
          end else if (j_r == IW'(1)) begin
            state_nxt = tkmh_pkg::ST_EMIT_RD;
          end else begin
            state_nxt = tkmh_pkg::ST_SORT_RD;
          end
        end else if (state_r == tkmh_pkg::ST_SIFT_RD) begin
          state_nxt = tkmh_pkg::ST_SIFT_CMP;
        end else begin
          state_nxt = tkmh_pkg::ST_SIFT_RD;
        end
      end
      tkmh_pkg::ST_SORT_RD: begin
        state_nxt = tkmh_pkg::ST_SORT_SWAP;
      end
      tkmh_pkg::ST_SORT_SWAP: begin
        state_nxt = tkmh_pkg::ST_SIFT_RD;
      end
      tkmh_pkg::ST_ROOT_RD: begin
        state_nxt = tkmh_pkg::ST_ROOT_OUT;
      end
      tkmh_pkg::ST_ROOT_OUT: begin
        if (can_load) begin
          state_nxt = tkmh_pkg::ST_IDLE;
        end
      end
      tkmh_pkg::ST_EMIT_RD: begin
        state_nxt = tkmh_pkg::ST_EMIT_OUT;
      end
      tkmh_pkg::ST_EMIT_OUT: begin
        if (can_load) begin
          state_nxt = (e_r == last_idx_r) ? tkmh_pkg::ST_IDLE : tkmh_pkg::ST_EMIT_RD;
        end
      end
      default: begin
        state_nxt = tkmh_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    req      = '0;
    in_stall = 1'b1;
    out_load = 1'b0;
    out_last = 1'b0;
    case (state_r)
      tkmh_pkg::ST_IDLE: begin
        in_stall = 1'b0;
      end
      tkmh_pkg::ST_SIFT_RD: begin
        req.rd_a = tkmh_pkg::ADDR_W'(left_idx[IW-1:0]);
        req.rd_b = tkmh_pkg::ADDR_W'(right_idx[IW-1:0]);
        if (!left_ok) begin
          req.wr_en   = 1'b1;
          req.wr_addr = tkmh_pkg::ADDR_W'(t_r);
          req.wr_data = held_r;
        end
      end
      tkmh_pkg::ST_SIFT_CMP: begin
        req.wr_en   = 1'b1;
        req.wr_addr = tkmh_pkg::ADDR_W'(t_r);
        req.wr_data = move ? win_entry : held_r;
      end
      tkmh_pkg::ST_SORT_RD: begin
        req.rd_b = tkmh_pkg::ADDR_W'(j_r);
      end
      tkmh_pkg::ST_SORT_SWAP: begin
        req.wr_en   = 1'b1;
        req.wr_addr = tkmh_pkg::ADDR_W'(j_r);
        req.wr_data = rd_data_a;
      end
      tkmh_pkg::ST_ROOT_RD: begin
      end
      tkmh_pkg::ST_ROOT_OUT: begin
        out_load = can_load;
        out_last = 1'b1;
      end
      tkmh_pkg::ST_EMIT_RD, tkmh_pkg::ST_EMIT_OUT: begin
        req.rd_a = tkmh_pkg::ADDR_W'(e_r);
        out_load = (state_r == tkmh_pkg::ST_EMIT_OUT) && can_load;
        out_last = e_r == last_idx_r;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tkmh_pkg::ST_IDLE;
      size_r      <= tkmh_pkg::SIZE_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) begin
        size_r <= cfg_active_size;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      held_r      <= '{used: 1'b1, word: in_data.new_word_id, count: in_data.new_count};
      t_r         <= '0;
      top_r       <= last_idx;
      j_r         <= last_idx;
      last_idx_r  <= last_idx;
      e_r         <= '0;
      sort_mode_r <= in_data.opcode == tkmh_pkg::OP_SORT;
    end
    if ((state_r == tkmh_pkg::ST_SIFT_CMP) && move) begin
      t_r <= win_idx;
    end
    if (state_r == tkmh_pkg::ST_SORT_SWAP) begin
      held_r <= rd_data_b;
      t_r    <= '0;
      top_r  <= j_r - IW'(1);
    end
    if (sift_done && sort_mode_r) begin
      j_r <= j_r - IW'(1);
    end
    if ((state_r == tkmh_pkg::ST_EMIT_OUT) && can_load) begin
      e_r <= e_r + IW'(1);
    end
    if (out_load) begin
      out_item_r <= '{word_id: rd_data_a.word, count: rd_data_a.count,
                      occupied: rd_data_a.used, last: out_last};
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_item_r;

endmodule

>>> sim/tkmh_checker.sv
`timescale 1ns / 1ps
// Checker for the top-k min-heap core: watches the input, result and size
// channels, keeps its own heap to predict every result and compares them.
// Depends on tkmh_pkg.
module tkmh_checker (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  logic                        in_stall,
  input  tkmh_pkg::in_item_t          in_data,
  input  logic                        out_valid,
  input  logic                        out_stall,
  input  tkmh_pkg::out_item_t         out_data,
  input  logic                        cfg_valid,
  input  logic                        cfg_ready,
  input  logic [tkmh_pkg::SIZE_W-1:0] cfg_active_size,
  output int                          fail_count,
  output int                          pending,
  output int                          results_seen
);

  localparam int DEPTH = tkmh_pkg::HEAP_DEPTH_DEF;

  tkmh_pkg::entry_t            heap_store [DEPTH];
  logic [tkmh_pkg::SIZE_W-1:0] size_reg;
  tkmh_pkg::out_item_t         expected_q [$];
  int                          errors = 0;
  int                          seen = 0;

  function automatic int active_entries();
    if (size_reg == '0) return 1;
    if (size_reg > DEPTH) return DEPTH;
    return int'(size_reg);
  endfunction

  function automatic void swap_slots(int a, int b);
    tkmh_pkg::entry_t tmp;
    tmp = heap_store[a];
    heap_store[a] = heap_store[b];
    heap_store[b] = tmp;
  endfunction

  function automatic void sift_down(int top, int start);
    int t, l, r, m;
    t = start;
    while (t < DEPTH) begin
      l = 2 * t + 1;
      r = 2 * t + 2;
      m = t;
      if (l <= top && l < DEPTH) begin
        m = (heap_store[l].count < heap_store[t].count) ? l : t;
        if (r <= top && r < DEPTH) begin
          m = (heap_store[m].count < heap_store[r].count) ? m : r;
        end
      end
      if (m == t) break;
      swap_slots(m, t);
      t = m;
    end
  endfunction

  function automatic tkmh_pkg::out_item_t slot_result(int slot, logic fin);
    tkmh_pkg::out_item_t res;
    res.word_id  = heap_store[slot].word;
    res.count    = heap_store[slot].count;
    res.occupied = heap_store[slot].used;
    res.last     = fin;
    return res;
  endfunction

  function automatic void predict_item(tkmh_pkg::in_item_t item);
    int n;
    n = active_entries();
    if (item.opcode == tkmh_pkg::OP_REPLACE) begin
      heap_store[0].used  = 1'b1;
      heap_store[0].word  = item.new_word_id;
      heap_store[0].count = item.new_count;
      sift_down(n - 1, 0);
      expected_q.push_back(slot_result(0, 1'b1));
    end else begin
      for (int j = n - 1; j > 0; j--) begin
        swap_slots(0, j);
        sift_down(j - 1, 0);
      end
      for (int j = 0; j < n; j++) begin
        expected_q.push_back(slot_result(j, j == n - 1));
      end
    end
  endfunction

  task automatic report(input string msg);
    $display("%0t ns: mismatch: %s", $time, msg);
    errors++;
  endtask

  task automatic check_result(input tkmh_pkg::out_item_t got);
    tkmh_pkg::out_item_t want;
    if (expected_q.size() == 0) begin
      report($sformatf("result word 0x%0h count 0x%0h with nothing expected",
                       got.word_id, got.count));
      return;
    end
    want = expected_q.pop_front();
    if (got.word_id !== want.word_id) begin
      report($sformatf("word_id 0x%0h, expected 0x%0h", got.word_id, want.word_id));
    end
    if (got.count !== want.count) begin
      report($sformatf("count 0x%0h, expected 0x%0h", got.count, want.count));
    end
    if (got.occupied !== want.occupied) begin
      report($sformatf("occupied %b, expected %b", got.occupied, want.occupied));
    end
    if (got.last !== want.last) begin
      report($sformatf("last %b, expected %b", got.last, want.last));
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < DEPTH; i++) heap_store[i] = '0;
      size_reg = tkmh_pkg::SIZE_RESET;
      expected_q.delete();
    end else begin
      if (out_valid && !out_stall) begin
        seen++;
        check_result(out_data);
      end
      if (cfg_valid && cfg_ready) size_reg = cfg_active_size;
      if (in_valid && !in_stall) predict_item(in_data);
    end
    fail_count   <= errors;
    pending      <= expected_q.size();
    results_seen <= seen;
  end

endmodule

>>> sim/tb.sv
`timescale 1ns / 1ps
// Testbench top for the top-k min-heap core: clock, reset, stimulus, idling
// and verdict. Depends on tkmh_pkg, top_k_min_heap_core and tkmh_checker.
module tb;

  localparam int ITEM_TARGET = 460;
  localparam int IDLE_LIMIT  = 5000;

  logic                        clk = 1'b0;
  logic                        rst_n;
  logic                        in_valid;
  logic                        in_stall;
  tkmh_pkg::in_item_t          in_data;
  logic                        out_valid;
  logic                        out_stall;
  tkmh_pkg::out_item_t         out_data;
  logic                        cfg_valid;
  logic                        cfg_ready;
  logic [tkmh_pkg::SIZE_W-1:0] cfg_active_size;

  int   fail_count;
  int   pending;
  int   results_seen;
  int   items_sent = 0;
  int   sorts_sent = 0;
  int   size_writes = 0;
  int   idle_cycles = 0;
  int   stall_hold = 0;
  logic calm = 1'b0;

  top_k_min_heap_core dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_data         (in_data),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_data        (out_data),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_active_size (cfg_active_size)
  );

  tkmh_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_data         (in_data),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_data        (out_data),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_active_size (cfg_active_size),
    .fail_count      (fail_count),
    .pending         (pending),
    .results_seen    (results_seen)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  function automatic logic [tkmh_pkg::COUNT_W-1:0] pick_count();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return tkmh_pkg::COUNT_W'($urandom_range(0, 7));
      4:          return '0;
      5:          return '1;
      default:    return tkmh_pkg::COUNT_W'($urandom);
    endcase
  endfunction

  function automatic logic [tkmh_pkg::SIZE_W-1:0] pick_size();
    case ($urandom_range(0, 19))
      0:          return '0;
      1:          return tkmh_pkg::SIZE_W'(1);
      2:          return tkmh_pkg::SIZE_W'(32);
      3:          return tkmh_pkg::SIZE_W'($urandom_range(33, 63));
      4, 5, 6, 7: return tkmh_pkg::SIZE_W'($urandom_range(9, 32));
      default:    return tkmh_pkg::SIZE_W'($urandom_range(1, 8));
    endcase
  endfunction

  always @(posedge clk) begin
    if (stall_hold != 0) begin
      stall_hold--;
    end else begin
      stall_hold = pick_gap();
      out_stall <= (stall_hold != 0);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Timeout: no transfer for %0d cycles, %0d results outstanding.",
               IDLE_LIMIT, pending);
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic send_item(input tkmh_pkg::in_item_t item);
    int gap;
    gap = pick_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (in_stall);
    items_sent++;
    if (item.opcode == tkmh_pkg::OP_SORT) sorts_sent++;
  endtask

  task automatic replace_root(input logic [tkmh_pkg::WORD_W-1:0] word,
                              input logic [tkmh_pkg::COUNT_W-1:0] cnt);
    tkmh_pkg::in_item_t item;
    item.opcode      = tkmh_pkg::OP_REPLACE;
    item.new_word_id = word;
    item.new_count   = cnt;
    send_item(item);
  endtask

  task automatic sort_all();
    tkmh_pkg::in_item_t item;
    item.opcode      = tkmh_pkg::OP_SORT;
    item.new_word_id = tkmh_pkg::WORD_W'($urandom);
    item.new_count   = tkmh_pkg::COUNT_W'($urandom);
    send_item(item);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic write_size(input logic [tkmh_pkg::SIZE_W-1:0] value);
    cfg_valid       <= 1'b1;
    cfg_active_size <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    size_writes++;
  endtask

  initial begin
    int batch;
    rst_n           = 1'b0;
    in_valid        = 1'b0;
    in_data         = '0;
    out_stall       = 1'b0;
    cfg_valid       = 1'b0;
    cfg_active_size = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // The heap is empty after reset, so the first sort emits empty entries only.
    sort_all();
    replace_root(16'hFFFF, 32'hFFFF_FFFF);
    replace_root(16'h0000, 32'h0000_0000);
    replace_root(16'h1234, 32'd5);
    replace_root(16'h4321, 32'd5);
    replace_root(16'h8001, 32'd5);
    sort_all();
    drain();
    write_size('0);
    replace_root(16'h5555, 32'h5555_5555);
    replace_root(16'hAAAA, 32'hAAAA_AAAA);
    sort_all();
    drain();
    write_size(tkmh_pkg::SIZE_W'(2));
    replace_root(16'h00FF, 32'd9);
    replace_root(16'hFF00, 32'd9);
    replace_root(16'h0F0F, 32'd3);
    sort_all();
    drain();
    write_size(tkmh_pkg::SIZE_W'(63));
    replace_root(16'h0001, 32'd1);
    sort_all();
    drain();
    write_size(tkmh_pkg::SIZE_W'(33));
    sort_all();
    drain();
    write_size(tkmh_pkg::SIZE_W'(1));
    replace_root(16'h7FFF, 32'h8000_0000);
    sort_all();

    while (items_sent < ITEM_TARGET) begin
      drain();
      calm = ($urandom_range(0, 4) == 0);
      write_size(pick_size());
      batch = $urandom_range(8, 30);
      repeat (batch) begin
        if ($urandom_range(0, 9) == 0) begin
          sort_all();
        end else begin
          replace_root(tkmh_pkg::WORD_W'($urandom), pick_count());
        end
      end
      if ($urandom_range(0, 1) == 0) sort_all();
    end

    drain();
    repeat (40) @(posedge clk);
    $display("Sent %0d input transfers (%0d sorts) across %0d active-size writes.",
             items_sent, sorts_sent, size_writes);
    $display("Checked %0d results against the predicted heap contents.", results_seen);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/core/tkmh_pkg.sv
rtl/core/tkmh_store.sv
rtl/core/tkmh_ctrl.sv
rtl/core/top_k_min_heap_core.sv
sim/tkmh_checker.sv
sim/tb.sv
